// File: hdl/rcsfd_pkg.sv
// Shared types and constants of the remote-control serial frame decoder.
package rcsfd_pkg;

	localparam int FRAME_BYTES = 32;
	localparam int POS_W       = $clog2(FRAME_BYTES);
	localparam int CFG_INDEX_W = 4;

	localparam logic [7:0]       HEADER_BYTE   = 8'h20;
	localparam logic [15:0]      CSUM_INIT     = 16'hFFFF;
	localparam logic [POS_W-1:0] POS_HEADER    = POS_W'(0);
	localparam logic [POS_W-1:0] POS_CH_FIRST  = POS_W'(2);
	localparam logic [POS_W-1:0] POS_SUM_LAST  = POS_W'(29);
	localparam logic [POS_W-1:0] POS_CSUM_LO   = POS_W'(30);
	localparam logic [POS_W-1:0] POS_CSUM_HI   = POS_W'(31);
	localparam logic [3:0]       SW_FIRST      = 4'd4;
	localparam logic [3:0]       SW_LAST       = 4'd7;
	localparam logic [15:0]      OFFSET_RESET  = 16'd1500;
	localparam logic [15:0]      DIVISOR_RESET = 16'd500;

	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_OFFSET  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_SWITCH_DIVISOR = CFG_INDEX_W'(1);

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         channel_index;
		logic signed [15:0] channel_value;
		logic               is_switch;
		logic signed [15:0] switch_position;
		logic               last_of_frame;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic take_byte;
		logic chan_first;
		logic chan_next;
		logic calc;
		logic div_start;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic frame_good;
		logic needs_div;
		logic last_chan;
		logic div_busy;
		logic out_free;
	} dp_status_t;

endpackage

// File: hdl/rc_serial_frame_decoder.sv
// Top level of the remote-control serial frame decoder.
// Each received byte is taken in the cycle that it is offered, and the block is ready for the
// next byte in the following cycle unless that byte completes a frame with a good header and
// checksum. Such a byte starts the decoding of the stored channels, during which byte requests
// are stalled: each channel passes the calculate and emit states, a switch channel with a
// nonzero divisor also the divider start and wait states, in which the serial divider produces
// one quotient bit a cycle; emitting waits while results are stalled. The last result waits in
// the output register while the next byte is already accepted. Configuration writes are always
// taken and should only be issued while no frame is being decoded.
module rc_serial_frame_decoder #(
	parameter int CHANNEL_COUNT = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  rcsfd_pkg::in_item_t               in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output rcsfd_pkg::out_item_t              out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rcsfd_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [15:0]                       cfg_data
);
	import rcsfd_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	rcsfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	rcsfd_datapath #(
		.CHANNEL_COUNT (CHANNEL_COUNT)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_write (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	// While a result other than the last of a frame waits, the frame is still being decoded.
	a_midframe_stalls_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.last_of_frame) |-> in_stall)
		else $error("byte request not stalled while a frame is being decoded");

	a_last_is_final_channel: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.last_of_frame) |->
		(out_data.channel_index == 4'(CHANNEL_COUNT - 1)))
		else $error("last result of a frame carries the wrong channel");

	a_plain_channel_no_position: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.is_switch) |-> (out_data.switch_position == 16'sd0))
		else $error("switch position set on a plain channel");

	a_good_frame_starts_decode: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && status.frame_good) |=> in_stall)
		else $error("good frame did not start channel decoding");
endmodule

// File: hdl/rcsfd_div.sv
// Serial restoring divider: signed 16-bit dividend by unsigned 16-bit divisor, one bit a cycle.
module rcsfd_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [15:0] dividend,
	input  logic [15:0] divisor,
	output logic        busy,
	output logic [15:0] quotient
);
	logic        busy_q;
	logic [3:0]  cnt_q;
	logic        neg_q;
	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic [15:0] dividend_abs;
	logic [16:0] shifted;
	logic        fits;
	logic [16:0] diff;

	assign dividend_abs = dividend[15] ? 16'(~dividend + 16'd1) : dividend;
	assign shifted      = {rem_q, quo_q[15]};
	assign diff         = shifted - {1'b0, divisor};
	assign fits         = (shifted >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd15) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[15];
			rem_q <= '0;
			quo_q <= dividend_abs;
		end else if (busy_q) begin
			rem_q <= fits ? diff[15:0] : shifted[15:0];
			quo_q <= {quo_q[14:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = neg_q ? 16'(~quo_q + 16'd1) : quo_q;
endmodule

// File: hdl/rcsfd_datapath.sv
// Datapath: frame tracking, checksum, channel store, offset, divider and result register.
module rcsfd_datapath #(
	parameter int CHANNEL_COUNT = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rcsfd_pkg::in_item_t                 in_data,
	input  logic                                cfg_write,
	input  logic [rcsfd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [15:0]                         cfg_data,
	input  rcsfd_pkg::dp_cmd_t                  cmd,
	output rcsfd_pkg::dp_status_t               status,
	output logic                                out_valid,
	input  logic                                out_stall,
	output rcsfd_pkg::out_item_t                out_data
);
	import rcsfd_pkg::*;

	localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

	logic [15:0]      offset_q;
	logic [15:0]      divisor_q;
	logic [POS_W-1:0] pos_q;
	logic [15:0]      csum_q;
	logic             header_q;
	logic [7:0]       csum_lo_q;
	logic [15:0]      store_q [CHANNEL_COUNT];
	logic [CH_W-1:0]  chan_q;
	logic [15:0]      val_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic [POS_W-1:0] pos_eff;
	logic [3:0]       wr_chan;
	logic             in_chan_bytes;
	logic [3:0]       chan_idx;
	logic             is_sw;
	logic             div_busy;
	logic [15:0]      quotient;

	assign pos_eff       = in_data.frame_start ? POS_HEADER : pos_q;
	assign in_chan_bytes = (pos_eff >= POS_CH_FIRST) && (pos_eff <= POS_SUM_LAST);
	assign wr_chan       = 4'((pos_eff - POS_CH_FIRST) >> 1);
	assign chan_idx      = 4'(chan_q);
	assign is_sw         = (chan_idx >= SW_FIRST) && (chan_idx <= SW_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q  <= OFFSET_RESET;
			divisor_q <= DIVISOR_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_CENTER_OFFSET:  offset_q  <= cfg_data;
				REG_SWITCH_DIVISOR: divisor_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			csum_q    <= CSUM_INIT;
			header_q  <= 1'b0;
			csum_lo_q <= '0;
		end else if (cmd.take_byte) begin
			pos_q <= pos_eff + POS_W'(1);
			if (pos_eff == POS_HEADER) begin
				header_q <= (in_data.rx_byte == HEADER_BYTE);
				csum_q   <= CSUM_INIT - {8'd0, in_data.rx_byte};
			end else if (pos_eff <= POS_SUM_LAST) begin
				csum_q <= csum_q - {8'd0, in_data.rx_byte};
			end
			if (pos_eff == POS_CSUM_LO) begin
				csum_lo_q <= in_data.rx_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_byte && in_chan_bytes && (wr_chan < 4'(CHANNEL_COUNT))) begin
			if (!pos_eff[0]) begin
				store_q[wr_chan[CH_W-1:0]][7:0] <= in_data.rx_byte;
			end else begin
				store_q[wr_chan[CH_W-1:0]][15:8] <= in_data.rx_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q <= '0;
		end else if (cmd.chan_first) begin
			chan_q <= '0;
		end else if (cmd.chan_next) begin
			chan_q <= chan_q + CH_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			val_q <= store_q[chan_q] - offset_q;
		end
	end

	rcsfd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (val_q),
		.divisor  (divisor_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.channel_index   <= chan_idx;
			out_q.channel_value   <= val_q;
			out_q.is_switch       <= is_sw;
			out_q.switch_position <= status.needs_div ? quotient : 16'd0;
			out_q.last_of_frame   <= status.last_chan;
		end
	end

	assign status.frame_good = (pos_eff == POS_CSUM_HI) && header_q
	                           && ({in_data.rx_byte, csum_lo_q} == csum_q);
	assign status.needs_div  = is_sw && (divisor_q != 16'd0);
	assign status.last_chan  = (chan_q == CH_W'(CHANNEL_COUNT - 1));
	assign status.div_busy   = div_busy;
	assign status.out_free   = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule

// File: hdl/rcsfd_ctrl.sv
// Controller state machine that sequences byte intake and per-channel result generation.
module rcsfd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  rcsfd_pkg::dp_status_t status,
	output rcsfd_pkg::dp_cmd_t    cmd
);
	import rcsfd_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall      = 1'b0;
				cmd.take_byte = in_valid;
				if (in_valid && status.frame_good) begin
					cmd.chan_first = 1'b1;
					state_d        = ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = status.needs_div ? ST_DIV_START : ST_EMIT;
			end
			ST_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (!status.div_busy) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					if (status.last_chan) begin
						state_d = ST_IDLE;
					end else begin
						cmd.chan_next = 1'b1;
						state_d       = ST_CALC;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
